FILE: hw/rtl/sstf_pkg.sv
package sstf_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int TRACK_W      = 16;
  localparam int DIST_W       = TRACK_W + 1;
  localparam int SUM_W        = 22;

  // out of reach of any real seek, so the first unserved entry always wins
  localparam logic [DIST_W-1:0] DIST_NONE = {1'b1, {TRACK_W{1'b0}}};

  typedef struct packed {
    logic [TRACK_W-1:0] track_request;
    logic               is_last_request;
  } in_item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [TRACK_W-1:0] seek_distance;
    logic [SUM_W-1:0]   total_seek;
    logic               final_result;
  } out_item_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

FILE: hw/rtl/sstf_disk_scheduler_unit.sv
// after the last request of a job is accepted, each result takes a full scan of
// the held requests (ram read, compare into the running best), then S_EMIT, which
// waits out an output stall, loads the output register; requests load one per
// cycle while no job runs; the scan reads one entry per cycle from the request ram
// reset (rst_n low, synchronous): store empty, served mask clear, head,
// seek sum and start track zero, no result pending
module sstf_disk_scheduler_unit
  import sstf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TRACK_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  // fsm
  state_t state_r, state_nxt;

  // job bookkeeping
  logic [CNT_W-1:0]   req_count_r, req_count_nxt;
  logic [CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic [CNT_W-1:0]   served_cnt_r, served_cnt_nxt;
  logic [MAX_REQUESTS-1:0] served_mask_r, served_mask_nxt;
  logic [TRACK_W-1:0] head_r, head_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [TRACK_W-1:0] start_track_r;

  // read stage of the scan, aligned with the ram output
  logic               rd_valid_r;
  logic               rd_last_r;
  logic               rd_served_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [TRACK_W-1:0] rd_track;

  // running best of the current scan
  logic [DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]   pick_idx_r, pick_idx_nxt;
  logic [TRACK_W-1:0] pick_track_r, pick_track_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // handshake and control strobes
  logic               in_acc;
  logic               job_start;
  logic               store_full;
  logic               store_we;
  logic               issue_en;
  logic               out_free;
  logic               emit_go;
  logic               emit_final;
  logic [IDX_W-1:0]   issue_addr;
  logic [TRACK_W-1:0] seek_gap;
  logic               better;
  logic [SUM_W-1:0]   sum_step;

  assign issue_addr = issue_cnt_r[IDX_W-1:0];
  assign store_full = (req_count_r >= CNT_W'(MAX_REQUESTS));
  assign out_free   = !out_valid_r || !out_stall;
  assign emit_final = ((served_cnt_r + CNT_W'(1)) == req_count_r);

  // request store: written while loading, read once per cycle while scanning
  sstf_req_ram #(
    .DEPTH (MAX_REQUESTS),
    .WIDTH (TRACK_W)
  ) u_req_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (req_count_r[IDX_W-1:0]),
    .wdata (in_data.track_request),
    .raddr (issue_addr),
    .rdata (rd_track)
  );

  // ---------------------------------------------------------------------------
  // fsm: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (job_start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // the last entry's compare lands this edge; the pick is then final
        if (rd_valid_r && rd_last_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = emit_final ? S_LOAD : S_SCAN;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // fsm: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    issue_en = 1'b0;
    emit_go  = 1'b0;
    unique case (state_r)
      S_LOAD: in_stall = 1'b0;
      S_SCAN: issue_en = (issue_cnt_r < req_count_r);
      S_EMIT: emit_go  = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_acc    = in_valid && !in_stall;
  assign job_start = in_acc && in_data.is_last_request;
  // a request beyond a full store is dropped, the job still runs
  assign store_we  = in_acc && !store_full;

  // distance from the head to the entry coming out of the ram
  assign seek_gap = (rd_track >= head_r) ? (rd_track - head_r) : (head_r - rd_track);
  // strict compare keeps the lowest index on ties
  assign better = rd_valid_r && !rd_served_r && ({1'b0, seek_gap} < best_dist_r);

  assign sum_step = sum_r + SUM_W'(best_dist_r);

  // ---------------------------------------------------------------------------
  // datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    req_count_nxt   = req_count_r;
    issue_cnt_nxt   = issue_cnt_r;
    served_cnt_nxt  = served_cnt_r;
    served_mask_nxt = served_mask_r;
    head_nxt        = head_r;
    sum_nxt         = sum_r;
    best_dist_nxt   = best_dist_r;
    pick_idx_nxt    = pick_idx_r;
    pick_track_nxt  = pick_track_r;

    if (store_we) begin
      req_count_nxt = req_count_r + CNT_W'(1);
    end

    if (job_start) begin
      served_mask_nxt = '0;
      head_nxt        = start_track_r;
      sum_nxt         = '0;
      issue_cnt_nxt   = '0;
      served_cnt_nxt  = '0;
      best_dist_nxt   = DIST_NONE;
    end

    if (issue_en) begin
      issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
    end

    if (better) begin
      best_dist_nxt  = {1'b0, seek_gap};
      pick_idx_nxt   = rd_idx_r;
      pick_track_nxt = rd_track;
    end

    if (emit_go) begin
      served_mask_nxt[pick_idx_r] = 1'b1;
      head_nxt       = pick_track_r;
      sum_nxt        = sum_step;
      served_cnt_nxt = served_cnt_r + CNT_W'(1);
      issue_cnt_nxt  = '0;
      best_dist_nxt  = DIST_NONE;
      if (emit_final) begin
        req_count_nxt = '0;
      end
    end
  end

  assign out_valid_nxt = emit_go || (out_valid_r && out_stall);

  // ---------------------------------------------------------------------------
  // control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      req_count_r   <= '0;
      issue_cnt_r   <= '0;
      served_cnt_r  <= '0;
      served_mask_r <= '0;
      head_r        <= '0;
      sum_r         <= '0;
      start_track_r <= '0;
      rd_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      req_count_r   <= req_count_nxt;
      issue_cnt_r   <= issue_cnt_nxt;
      served_cnt_r  <= served_cnt_nxt;
      served_mask_r <= served_mask_nxt;
      head_r        <= head_nxt;
      sum_r         <= sum_nxt;
      rd_valid_r    <= issue_en;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        start_track_r <= cfg_wdata;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_idx_r     <= issue_addr;
    rd_last_r    <= ((issue_cnt_r + CNT_W'(1)) == req_count_r);
    rd_served_r  <= served_mask_r[issue_addr];
    best_dist_r  <= best_dist_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_track_r <= pick_track_nxt;
    if (emit_go) begin
      out_data_r.served_track  <= pick_track_r;
      out_data_r.seek_distance <= best_dist_r[TRACK_W-1:0];
      out_data_r.total_seek    <= sum_step;
      out_data_r.final_result  <= emit_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/sstf_req_ram.sv
module sstf_req_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sstf_checker.sv
module sstf_checker
  import sstf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the last request of a job starts the schedule, no loading meanwhile
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.is_last_request |=> in_stall)
    else $error("input taken right after job start");

  // while a result that is not the job's final one is shown, the job is running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_result |-> in_stall)
    else $error("input taken in the middle of a job");

  // running total always covers the seek it includes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.total_seek >= SUM_W'(out_data.seek_distance)))
    else $error("total seek below seek distance");

endmodule

bind sstf_disk_scheduler_unit sstf_checker u_sstf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
